>>> hdl/dq_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the double-ended queue: default sizes, request and
// status codes, and the command/status bundles between controller and datapath.
package dq_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [1:0] REQ_PUSH_BACK  = 2'd0;
  localparam logic [1:0] REQ_PUSH_FRONT = 2'd1;
  localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
  localparam logic [1:0] REQ_POP_BACK   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic load;
    logic commit;
  } dq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dq_sts_t;

endpackage

>>> hdl/double_ended_queue_core.sv
`timescale 1ns / 1ps
// Double-ended queue of data words on stream ports: controller plus datapath.
// Depends on dq_pkg, dq_ctrl and dq_datapath.
//
// Each request pushes a word at the back or front, or pops one from the
// front or back, and yields one result word with the popped data, the entry
// count after the request and a status. The accept cycle registers the request
// and issues the registered read of the word store; the commit cycle then
// commits pointers, count and any write, and loads the result register. A new
// request is accepted only after the previous one commits; a request waits in
// its commit cycle while the previous result is not taken.
// The store needs no clearing after reset, so requests are accepted at once.
module double_ended_queue_core #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF,
  localparam int CNT_W     = $clog2(DEPTH + 1),
  localparam int IN_W      = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_W     = ((DATA_WIDTH + CNT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // data_in
  input  logic [1:0]       s_tuser,   // req_type
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // data_out, entry_count
  output logic [1:0]       m_tuser    // status
);
  import dq_pkg::*;

  dq_cmd_t               cmd;
  dq_sts_t               sts;
  logic [DATA_WIDTH-1:0] out_data;
  logic [CNT_W-1:0]      out_count;

  dq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  dq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_req     (s_tuser),
    .in_data    (s_tdata[DATA_WIDTH-1:0]),
    .out_data   (out_data),
    .out_count  (out_count),
    .out_status (m_tuser)
  );

  assign m_tdata = OUT_W'({out_count, out_data});

  assert property (@(posedge clk) disable iff (rst) !(sts.full && sts.empty))
    else $error("queue flagged full and empty at once");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_FULL) |-> (out_count == CNT_W'(DEPTH)))
    else $error("full drop reported with queue not full");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_EMPTY) |-> (out_count == '0) && (out_data == '0))
    else $error("empty pop reported with entries held or nonzero data");

  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !s_tready)
    else $error("commit while accepting a new word");

endmodule

>>> hdl/dq_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the double-ended queue: accepts a request, then commits it
// once the output register is free. Depends on dq_pkg.
module dq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  output dq_pkg::dq_cmd_t cmd
);
  import dq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic m_tvalid_next;

  assign s_tready   = (state == S_IDLE);
  assign cmd.load   = s_tvalid && s_tready;
  assign cmd.commit = (state == S_EXEC) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.load) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) m_tvalid_next = 1'b1;
    else if (m_tready) m_tvalid_next = 1'b0;
    else m_tvalid_next = m_tvalid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

>>> hdl/dq_datapath.sv
`timescale 1ns / 1ps
// Datapath of the double-ended queue: circular word store, head index, entry
// count and result register. Depends on dq_pkg.
module dq_datapath #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF,
  localparam int IDX_W     = $clog2(DEPTH),
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dq_pkg::dq_cmd_t       cmd,
  output dq_pkg::dq_sts_t       sts,
  input  logic [1:0]            in_req,
  input  logic [DATA_WIDTH-1:0] in_data,
  output logic [DATA_WIDTH-1:0] out_data,
  output logic [CNT_W-1:0]      out_count,
  output logic [1:0]            out_status
);
  import dq_pkg::*;

  localparam int SUM_W = CNT_W + 1;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [1:0]            req_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic [DATA_WIDTH-1:0] rdata;
  logic [IDX_W-1:0]      head;
  logic [CNT_W-1:0]      count;

  logic [SUM_W-1:0]      sum_tail;
  logic [SUM_W-1:0]      sum_last;
  logic [SUM_W-1:0]      wrap_tail;
  logic [SUM_W-1:0]      wrap_last;
  logic [IDX_W-1:0]      tail_idx;
  logic [IDX_W-1:0]      last_idx;
  logic [IDX_W-1:0]      front_idx;
  logic [IDX_W-1:0]      head_inc;
  logic [IDX_W-1:0]      rd_addr;

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [IDX_W-1:0]      head_next;
  logic [CNT_W-1:0]      count_next;
  logic [DATA_WIDTH-1:0] res_data;
  logic [1:0]            res_status;

  assign sts.full  = (count == CNT_W'(DEPTH));
  assign sts.empty = (count == '0);

  assign sum_tail  = SUM_W'(head) + SUM_W'(count);
  assign sum_last  = sum_tail - SUM_W'(1);
  assign wrap_tail = (sum_tail >= SUM_W'(DEPTH)) ? sum_tail - SUM_W'(DEPTH) : sum_tail;
  assign wrap_last = (sum_last >= SUM_W'(DEPTH)) ? sum_last - SUM_W'(DEPTH) : sum_last;
  assign tail_idx  = wrap_tail[IDX_W-1:0];
  assign last_idx  = wrap_last[IDX_W-1:0];
  assign front_idx = (head == '0) ? IDX_W'(DEPTH - 1) : head - IDX_W'(1);
  assign head_inc  = (head == IDX_W'(DEPTH - 1)) ? '0 : head + IDX_W'(1);
  assign rd_addr   = (in_req == REQ_POP_FRONT) ? head : last_idx;

  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = tail_idx;
    head_next  = head;
    count_next = count;
    res_data   = '0;
    res_status = ST_OK;
    case (req_q)
      REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
        if (data_q == '0) begin
          res_status = ST_NULL;
        end else if (sts.full) begin
          res_status = ST_FULL;
        end else begin
          wr_en      = 1'b1;
          count_next = count + CNT_W'(1);
          if (req_q == REQ_PUSH_FRONT) begin
            wr_addr   = front_idx;
            head_next = front_idx;
          end
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (sts.empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_data   = rdata;
          count_next = count - CNT_W'(1);
          if (req_q == REQ_POP_FRONT) head_next = head_inc;
        end
      end
      default: res_status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q  <= in_req;
      data_q <= in_data;
      rdata  <= mem[rd_addr];
    end
    if (cmd.commit && wr_en) begin
      mem[wr_addr] <= data_q;
    end
    if (cmd.commit) begin
      out_data   <= res_data;
      out_count  <= count_next;
      out_status <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.commit) begin
      head  <= head_next;
      count <= count_next;
    end
  end

endmodule

>>> bench/tb_double_ended_queue_core.sv
`timescale 1ns / 1ps
// Self-checking bench for double_ended_queue_core: pushes and pops at both ends
// over the stream ports, predicted by an in-bench deque and compared per result.
// Depends on dq_pkg and double_ended_queue_core.
module tb_double_ended_queue_core;
  import dq_pkg::*;

  localparam int SLOTS     = DEPTH_DEF;
  localparam int WORD_W    = DATA_WIDTH_DEF;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int COUNT_W   = $clog2(SLOTS + 1);
  localparam int IN_W      = ((WORD_W + 7) / 8) * 8;
  localparam int OUT_W     = ((WORD_W + COUNT_W + 7) / 8) * 8;
  localparam int HOLD_LEN  = 250;

  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [COUNT_W-1:0] count;
    logic [1:0]         status;
  } deque_result_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_MOSTLY,
    READY_PERIODIC
  } ready_mode_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;   // data_in
  logic [1:0]       s_tuser = REQ_PUSH_BACK;   // req_type
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;   // data_out, entry_count
  logic [1:0]       m_tuser;   // status

  logic [WORD_W-1:0]  held_words [SLOTS];
  logic [SLOT_W-1:0]  front_slot = '0;
  logic [COUNT_W-1:0] held_count = '0;

  deque_result_t pending_results [$];
  int          mismatch_count = 0;
  int          burst_left = 4;
  bit          gaps_on = 1'b1;
  ready_mode_t ready_mode = READY_ALWAYS;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          stall_phase = 0;

  double_ended_queue_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic deque_result_t next_deque_result(input logic [1:0] req,
                                                      input logic [WORD_W-1:0] word);
    deque_result_t     r;
    logic [SLOT_W-1:0] slot;
    r.word   = '0;
    r.status = ST_OK;
    if (req == REQ_PUSH_BACK || req == REQ_PUSH_FRONT) begin
      if (word == '0) begin
        r.status = ST_NULL;
      end else if (held_count == COUNT_W'(SLOTS)) begin
        r.status = ST_FULL;
      end else if (req == REQ_PUSH_BACK) begin
        slot = front_slot + held_count[SLOT_W-1:0];
        held_words[slot] = word;
        held_count = held_count + COUNT_W'(1);
      end else begin
        front_slot = front_slot - SLOT_W'(1);
        held_words[front_slot] = word;
        held_count = held_count + COUNT_W'(1);
      end
    end else begin
      if (held_count == '0) begin
        r.status = ST_EMPTY;
      end else if (req == REQ_POP_FRONT) begin
        r.word = held_words[front_slot];
        front_slot = front_slot + SLOT_W'(1);
        held_count = held_count - COUNT_W'(1);
      end else begin
        slot = front_slot + SLOT_W'(held_count - COUNT_W'(1));
        r.word = held_words[slot];
        held_count = held_count - COUNT_W'(1);
      end
    end
    r.count = held_count;
    return r;
  endfunction

  task automatic note_error(input string msg);
    if (mismatch_count < 10) $display("ERROR at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input longint unsigned expv,
                             input longint unsigned actv);
    if (expv != actv)
      note_error($sformatf("%s: expected %0h, got %0h", name, expv, actv));
  endtask

  // check each word taken from the result stream against the oldest prediction
  always @(posedge clk) begin
    deque_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected result data %0h count %0d status %0d",
                             m_tdata[WORD_W-1:0], m_tdata[WORD_W +: COUNT_W], m_tuser));
      end else begin
        want = pending_results.pop_front();
        check_field("data_out", want.word, m_tdata[WORD_W-1:0]);
        check_field("entry_count", want.count, m_tdata[WORD_W +: COUNT_W]);
        check_field("status", want.status, m_tuser);
      end
    end
  end

  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_LEN;
      m_tready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      case (ready_mode)
        READY_ALWAYS:   m_tready <= 1'b1;
        READY_COIN:     m_tready <= 1'($urandom_range(0, 1));
        READY_MOSTLY:   m_tready <= ($urandom_range(0, 9) < 8);
        READY_PERIODIC: m_tready <= ((stall_phase % 7) < 4);
        default:        m_tready <= 1'b1;
      endcase
    end
  end

  task automatic offer_request(input logic [1:0] req, input logic [WORD_W-1:0] word);
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= IN_W'(word);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(next_deque_result(req, word));
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return WORD_W'(1);
      2:       return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_nonnull_word();
    logic [WORD_W-1:0] w;
    w = pick_word();
    return (w == '0) ? WORD_W'(32'h5A5A_0001) : w;
  endfunction

  task automatic test_empty_null_and_ends();
    offer_request(REQ_POP_FRONT, 32'hDEAD_BEEF);
    offer_request(REQ_POP_BACK, 32'h0000_0000);
    offer_request(REQ_PUSH_BACK, 32'h0000_0000);
    offer_request(REQ_PUSH_FRONT, 32'h0000_0000);
    offer_request(REQ_PUSH_FRONT, 32'h0000_0001);
    offer_request(REQ_PUSH_BACK, 32'hFFFF_FFFF);
    offer_request(REQ_PUSH_FRONT, 32'h7FFF_FFFF);
    offer_request(REQ_PUSH_BACK, 32'h8000_0000);
    offer_request(REQ_POP_BACK, 32'hFFFF_FFFF);
    offer_request(REQ_POP_FRONT, 32'h0000_0000);
    offer_request(REQ_POP_FRONT, 32'h0000_0000);
    offer_request(REQ_POP_BACK, 32'h0000_0000);
    offer_request(REQ_POP_BACK, 32'hFFFF_FFFF);
    offer_request(REQ_POP_FRONT, 32'h0000_0000);
    wait_drained();
  endtask

  // hold the result side off at the start, then push past full and push null words at both ends
  task automatic test_fill_under_holdoff();
    ready_mode    <= READY_ALWAYS;
    gaps_on       = 1'b0;
    hold_requests <= hold_requests + 1;
    repeat (SLOTS + 6) begin
      offer_request($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
                    pick_nonnull_word());
    end
    offer_request(REQ_PUSH_BACK, '0);
    offer_request(REQ_PUSH_FRONT, '0);
    wait_drained();
  endtask

  task automatic test_drain_both_ends();
    ready_mode <= READY_PERIODIC;
    gaps_on    = 1'b1;
    repeat (SLOTS + 6) begin
      offer_request($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK, $urandom);
    end
    wait_drained();
  endtask

  task automatic test_random_mix();
    int          push_pct;
    int          n;
    logic [1:0]  req;
    logic [WORD_W-1:0] word;
    push_pct = 50;
    for (n = 0; n < 250; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 25;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
        ready_mode <= ready_mode_t'($urandom_range(0, 3));
        gaps_on    = (n % 80) != 0;
      end
      if ($urandom_range(0, 99) < push_pct) begin
        req  = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
        word = ($urandom_range(0, 99) < 6) ? '0 : pick_word();
      end else begin
        req  = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
        word = $urandom;
      end
      offer_request(req, word);
      if (n == 160) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_null_and_ends();
    test_fill_under_holdoff();
    test_drain_both_ends();
    test_random_mix();
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_double_ended_queue_core: done, clean");
    end else begin
      $display("tb_double_ended_queue_core: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_double_ended_queue_core: done, errors");
    $finish;
  end

endmodule

>>> filelist.f
hdl/dq_pkg.sv
hdl/dq_ctrl.sv
hdl/dq_datapath.sv
hdl/double_ended_queue_core.sv
bench/tb_double_ended_queue_core.sv
